FILE: rtl/core/tld_pkg.sv
// Shared types, codes and sizes for the terminal line discipline.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
package tld_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int LINE_MAX    = 32;
  localparam int QADDR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LIDX_W      = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int LEN_W       = 6;
  localparam int COL_W       = 16;
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_W      = 1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;

  typedef enum logic [2:0] {
    OP_KEY       = 3'd0,
    OP_ENTER     = 3'd1,
    OP_BACKSPACE = 3'd2,
    OP_RAW_PUSH  = 3'd3,
    OP_READ      = 3'd4,
    OP_LINE_READ = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    K_ECHO_CHAR    = 3'd0,
    K_ECHO_NEWLINE = 3'd1,
    K_ECHO_ERASE   = 3'd2,
    K_READ_BYTE    = 3'd3,
    K_READ_DONE    = 3'd4,
    K_READ_REFUSED = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    REG_ECHO_ENABLE    = 2'd0,
    REG_CANONICAL_MODE = 2'd1,
    REG_CR_TO_LF       = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_RAW  = 2'd1,
    PEND_LINE = 2'd2
  } pend_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SERVICE,
    S_RAW_READ,
    S_RAW_EMIT,
    S_LINE_READ,
    S_LINE_CHECK,
    S_LINE_OUT,
    S_FINISH
  } back_state_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] key_byte;
    logic [5:0] max_len;
    logic       blocking;
  } in_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [5:0] count;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic echo_enable;
    logic canonical_mode;
    logic cr_to_lf;
  } cfg_t;

  typedef struct packed {
    logic             is_read;
    logic             line;
    logic [LEN_W-1:0] lim;
    logic             blk;
    logic             push;
    logic [7:0]       push_byte;
    logic             echo;
  } cmd_t;

endpackage

FILE: rtl/core/tld_front.sv
// Front end: accepts input words and turns them into queued commands.
// Depends on tld_pkg.
`timescale 1ns / 1ps
module tld_front (
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tld_pkg::in_word_t in_data,
  input  tld_pkg::cfg_t   cfg,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output tld_pkg::cmd_t   cmd
);

  tld_pkg::cmd_t c;
  logic          keep;
  logic          accepted;

  always_comb begin
    c = '0;
    keep = 1'b1;
    c.lim = (in_data.max_len > 6'(tld_pkg::LINE_MAX)) ? 6'(tld_pkg::LINE_MAX) : in_data.max_len;
    c.blk = in_data.blocking;
    case (in_data.opcode)
      tld_pkg::OP_KEY: begin
        c.push = !cfg.canonical_mode || (in_data.key_byte >= tld_pkg::CH_SPACE);
        c.echo = c.push && cfg.echo_enable;
        c.push_byte = in_data.key_byte;
      end
      tld_pkg::OP_ENTER: begin
        c.push = 1'b1;
        c.echo = cfg.echo_enable;
        c.push_byte = (cfg.canonical_mode && cfg.cr_to_lf) ? tld_pkg::CH_LF : tld_pkg::CH_CR;
      end
      tld_pkg::OP_BACKSPACE: begin
        c.push = !cfg.canonical_mode;
        c.echo = cfg.echo_enable;
        c.push_byte = tld_pkg::CH_DEL;
      end
      tld_pkg::OP_RAW_PUSH: begin
        c.push = 1'b1;
        c.push_byte = in_data.key_byte;
      end
      tld_pkg::OP_READ: begin
        c.is_read = 1'b1;
        c.line = cfg.canonical_mode;
      end
      tld_pkg::OP_LINE_READ: begin
        c.is_read = 1'b1;
        c.line = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  // Unknown opcodes are taken and dropped without reaching the queue.
  assign in_ready  = cmd_ready;
  assign accepted  = in_valid && in_ready;
  assign cmd_valid = accepted && keep && !rst;
  assign cmd       = c;

endmodule

FILE: rtl/core/tld_cmd_fifo.sv
// Short command queue between the front end and the execution engine.
// Depends on tld_pkg.
`timescale 1ns / 1ps
module tld_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tld_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tld_pkg::cmd_t rd_data
);

  tld_pkg::cmd_t              slots [tld_pkg::CMDQ_DEPTH];
  logic [tld_pkg::CMDQ_W-1:0] wptr;
  logic [tld_pkg::CMDQ_W-1:0] rptr;
  logic [tld_pkg::CMDQ_W:0]   used;
  logic                       do_wr;
  logic                       do_rd;

  assign wr_ready = (used != (tld_pkg::CMDQ_W+1)'(tld_pkg::CMDQ_DEPTH));
  assign rd_valid = (used != '0);
  assign rd_data  = slots[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   used <= used + 1'b1;
        2'b01:   used <= used - 1'b1;
        default: used <= used;
      endcase
    end
  end

endmodule

FILE: rtl/core/tld_back.sv
// Execution engine: byte queue, echo column, pending reads and line assembly.
// Depends on tld_pkg; holds the byte queue memory and the line buffer.
`timescale 1ns / 1ps
module tld_back (
  input  logic              clk,
  input  logic              rst,
  input  tld_pkg::cfg_t     cfg,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  tld_pkg::cmd_t     cmd_in,
  output logic              out_valid,
  input  logic              out_ready,
  output tld_pkg::out_word_t out_data
);

  localparam int QD = tld_pkg::QUEUE_DEPTH;
  localparam int LW = tld_pkg::LEN_W;

  tld_pkg::back_state_t state, state_next;
  tld_pkg::cmd_t        cmd, cmd_next;
  tld_pkg::pend_t       pend, pend_next;
  logic [tld_pkg::QADDR_W-1:0] head, head_next;
  logic [tld_pkg::QFILL_W-1:0] fill, fill_next;
  logic [tld_pkg::COL_W-1:0]   column, column_next;
  logic [LW-1:0] plim, plim_next;
  logic [LW-1:0] lfill, lfill_next;
  logic [LW-1:0] lim, lim_next;
  logic [LW-1:0] n, n_next;
  logic          blk, blk_next;

  logic [7:0] qmem [QD];
  logic [7:0] line_buf [tld_pkg::LINE_MAX];
  logic [7:0] rd_data;

  logic                        q_we, q_re, ls_we;
  logic [tld_pkg::QADDR_W-1:0] q_waddr;
  logic [7:0]                  ls_wdata;
  logic [tld_pkg::QFILL_W:0]   wsum;

  tld_pkg::out_word_t hold;
  tld_pkg::out_word_t hold_last;
  logic               hold_valid;
  logic               out_free, gen_ok, gen_valid, flush;
  tld_pkg::out_word_t gen;
  logic [7:0]         b2;
  logic [LW-1:0]      nf;

  assign out_free  = !out_valid || out_ready;
  assign gen_ok    = !hold_valid || out_free;
  assign cmd_ready = (state == tld_pkg::S_IDLE);

  always_comb begin
    hold_last      = hold;
    hold_last.last = 1'b1;
  end

  always_comb begin
    wsum = (tld_pkg::QFILL_W+1)'(head) + (tld_pkg::QFILL_W+1)'(fill);
    if (wsum >= (tld_pkg::QFILL_W+1)'(QD)) begin
      wsum = wsum - (tld_pkg::QFILL_W+1)'(QD);
    end
    q_waddr = wsum[tld_pkg::QADDR_W-1:0];
  end

  always_comb begin
    state_next = state;
    cmd_next = cmd;
    pend_next = pend;
    head_next = head;
    fill_next = fill;
    column_next = column;
    plim_next = plim;
    lfill_next = lfill;
    lim_next = lim;
    n_next = n;
    blk_next = blk;
    q_we = 1'b0;
    q_re = 1'b0;
    ls_we = 1'b0;
    ls_wdata = rd_data;
    gen_valid = 1'b0;
    gen = '0;
    flush = 1'b0;
    b2 = rd_data;
    nf = lfill;
    case (state)
      tld_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_next = cmd_in;
          state_next = tld_pkg::S_EXEC;
        end
      end
      tld_pkg::S_EXEC: begin
        if (gen_ok) begin
          if (cmd.is_read) begin
            if (pend != tld_pkg::PEND_NONE) begin
              gen_valid = 1'b1;
              gen.kind = tld_pkg::K_READ_REFUSED;
              state_next = tld_pkg::S_FINISH;
            end else if (cmd.lim == '0) begin
              gen_valid = 1'b1;
              gen.kind = tld_pkg::K_READ_DONE;
              state_next = tld_pkg::S_FINISH;
            end else if (cmd.line) begin
              lfill_next = '0;
              lim_next = cmd.lim;
              blk_next = cmd.blk;
              state_next = tld_pkg::S_LINE_READ;
            end else if (!cmd.blk) begin
              lim_next = LW'(1);
              n_next = '0;
              state_next = tld_pkg::S_RAW_READ;
            end else if (fill == '0) begin
              pend_next = tld_pkg::PEND_RAW;
              plim_next = cmd.lim;
              state_next = tld_pkg::S_FINISH;
            end else begin
              lim_next = cmd.lim;
              n_next = '0;
              state_next = tld_pkg::S_RAW_READ;
            end
          end else begin
            if (cmd.push && (fill < tld_pkg::QFILL_W'(QD))) begin
              q_we = 1'b1;
              fill_next = fill + 1'b1;
            end
            if (cmd.echo) begin
              if (cmd.push_byte == tld_pkg::CH_LF) begin
                column_next = '0;
                gen_valid = 1'b1;
                gen.kind = tld_pkg::K_ECHO_NEWLINE;
                gen.value = tld_pkg::CH_LF;
              end else if (cmd.push_byte == tld_pkg::CH_DEL) begin
                if (column != '0) begin
                  column_next = column - 1'b1;
                  gen_valid = 1'b1;
                  gen.kind = tld_pkg::K_ECHO_ERASE;
                end
              end else if (cmd.push_byte >= tld_pkg::CH_SPACE) begin
                if (column != '1) begin
                  column_next = column + 1'b1;
                end
                gen_valid = 1'b1;
                gen.kind = tld_pkg::K_ECHO_CHAR;
                gen.value = cmd.push_byte;
              end
            end
            state_next = tld_pkg::S_SERVICE;
          end
        end
      end
      tld_pkg::S_SERVICE: begin
        if ((pend == tld_pkg::PEND_RAW) && (fill != '0)) begin
          lim_next = plim;
          n_next = '0;
          state_next = tld_pkg::S_RAW_READ;
        end else if (pend == tld_pkg::PEND_LINE) begin
          lim_next = plim;
          blk_next = 1'b1;
          state_next = tld_pkg::S_LINE_READ;
        end else begin
          state_next = tld_pkg::S_FINISH;
        end
      end
      tld_pkg::S_RAW_READ: begin
        if ((n < lim) && (fill != '0)) begin
          q_re = 1'b1;
          head_next = (head == tld_pkg::QADDR_W'(QD - 1)) ? '0 : head + 1'b1;
          fill_next = fill - 1'b1;
          n_next = n + 1'b1;
          state_next = tld_pkg::S_RAW_EMIT;
        end else if (gen_ok) begin
          gen_valid = 1'b1;
          gen.kind = tld_pkg::K_READ_DONE;
          gen.count = n;
          pend_next = tld_pkg::PEND_NONE;
          plim_next = '0;
          state_next = tld_pkg::S_FINISH;
        end
      end
      tld_pkg::S_RAW_EMIT: begin
        if (gen_ok) begin
          gen_valid = 1'b1;
          gen.kind = tld_pkg::K_READ_BYTE;
          gen.value = rd_data;
          state_next = tld_pkg::S_RAW_READ;
        end
      end
      tld_pkg::S_LINE_READ: begin
        if (fill == '0) begin
          if (!blk) begin
            if (gen_ok) begin
              lfill_next = '0;
              gen_valid = 1'b1;
              gen.kind = tld_pkg::K_READ_DONE;
              state_next = tld_pkg::S_FINISH;
            end
          end else begin
            pend_next = tld_pkg::PEND_LINE;
            plim_next = lim;
            state_next = tld_pkg::S_FINISH;
          end
        end else begin
          q_re = 1'b1;
          head_next = (head == tld_pkg::QADDR_W'(QD - 1)) ? '0 : head + 1'b1;
          fill_next = fill - 1'b1;
          state_next = tld_pkg::S_LINE_CHECK;
        end
      end
      tld_pkg::S_LINE_CHECK: begin
        if ((rd_data == tld_pkg::CH_DEL) || (rd_data == tld_pkg::CH_BS)) begin
          if (lfill != '0) begin
            lfill_next = lfill - 1'b1;
          end
          state_next = tld_pkg::S_LINE_READ;
        end else begin
          if (cfg.cr_to_lf && (rd_data == tld_pkg::CH_CR)) begin
            b2 = tld_pkg::CH_LF;
          end
          if (lfill < LW'(tld_pkg::LINE_MAX)) begin
            ls_we = 1'b1;
            ls_wdata = b2;
            nf = lfill + 1'b1;
          end
          lfill_next = nf;
          if ((b2 == tld_pkg::CH_LF) || (nf >= lim) || (nf >= LW'(tld_pkg::LINE_MAX))) begin
            n_next = '0;
            state_next = tld_pkg::S_LINE_OUT;
          end else begin
            state_next = tld_pkg::S_LINE_READ;
          end
        end
      end
      tld_pkg::S_LINE_OUT: begin
        if (gen_ok) begin
          gen_valid = 1'b1;
          if (n < lfill) begin
            gen.kind = tld_pkg::K_READ_BYTE;
            gen.value = line_buf[n[tld_pkg::LIDX_W-1:0]];
            n_next = n + 1'b1;
          end else begin
            gen.kind = tld_pkg::K_READ_DONE;
            gen.count = lfill;
            lfill_next = '0;
            pend_next = tld_pkg::PEND_NONE;
            plim_next = '0;
            state_next = tld_pkg::S_FINISH;
          end
        end
      end
      tld_pkg::S_FINISH: begin
        if (!hold_valid) begin
          state_next = tld_pkg::S_IDLE;
        end else if (out_free) begin
          flush = 1'b1;
          state_next = tld_pkg::S_IDLE;
        end
      end
      default: state_next = tld_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= cmd.push_byte;
    end
    if (q_re) begin
      rd_data <= qmem[head];
    end
    if (ls_we) begin
      line_buf[lfill[tld_pkg::LIDX_W-1:0]] <= ls_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    lim <= lim_next;
    n   <= n_next;
    blk <= blk_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tld_pkg::S_IDLE;
      pend   <= tld_pkg::PEND_NONE;
      head   <= '0;
      fill   <= '0;
      column <= '0;
      plim   <= '0;
      lfill  <= '0;
    end else begin
      state  <= state_next;
      pend   <= pend_next;
      head   <= head_next;
      fill   <= fill_next;
      column <= column_next;
      plim   <= plim_next;
      lfill  <= lfill_next;
    end
  end

  // One result is held back so that the final one of an item can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (gen_valid) begin
        if (hold_valid) begin
          out_data  <= hold;
          out_valid <= 1'b1;
        end
        hold       <= gen;
        hold_valid <= 1'b1;
      end
      if (flush) begin
        out_data   <= hold_last;
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/tty_line_discipline.sv
// Top level of the terminal input line discipline.
// Depends on tld_pkg, tld_front, tld_cmd_fifo and tld_back.
`timescale 1ns / 1ps
// Key events and raw pushes fill a byte queue, with echo words for keys when
// echo is on; reads return queued bytes either raw or as edited lines. Input
// words are classified by a front end and passed through a two-entry command
// queue to an engine that works on one command at a time, so the input side
// keeps accepting while results wait at the output, until the queue is full.
// The engine pops the byte queue through a memory with a registered read
// port: a raw read fetches and then emits each returned byte, and a line read
// fetches and checks each consumed queue byte before it emits the line. Each
// result word is held back in a register so the final word of an item can be
// flagged last. Configuration registers are written through the cfg port,
// which is always ready; indexes outside the register list are ignored.
module tty_line_discipline (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tld_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tld_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data
);

  tld_pkg::cfg_t cfg;
  tld_pkg::cmd_t front_cmd, queued_cmd;
  logic          front_valid, front_ready, queued_valid, queued_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers; reset turns echo and CR-to-LF on and canonical mode off.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_enable    <= 1'b1;
      cfg.canonical_mode <= 1'b0;
      cfg.cr_to_lf       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tld_pkg::REG_ECHO_ENABLE:    cfg.echo_enable    <= cfg_data;
        tld_pkg::REG_CANONICAL_MODE: cfg.canonical_mode <= cfg_data;
        tld_pkg::REG_CR_TO_LF:       cfg.cr_to_lf       <= cfg_data;
        default: ;
      endcase
    end
  end

  tld_front u_front (
    .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cfg(cfg),
    .cmd_valid(front_valid), .cmd_ready(front_ready), .cmd(front_cmd)
  );

  tld_cmd_fifo u_cmdq (
    .clk(clk), .rst(rst),
    .wr_valid(front_valid), .wr_ready(front_ready), .wr_data(front_cmd),
    .rd_valid(queued_valid), .rd_ready(queued_ready), .rd_data(queued_cmd)
  );

  tld_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .cmd_valid(queued_valid), .cmd_ready(queued_ready), .cmd_in(queued_cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

FILE: rtl/core/tld_checker.sv
// Port-level checks for the terminal line discipline, bound to the top level.
// Depends on tld_pkg and tty_line_discipline.
`timescale 1ns / 1ps
module tld_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input tld_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_data.kind == tld_pkg::K_READ_DONE) ||
                  (out_data.kind == tld_pkg::K_READ_REFUSED)) |-> out_data.last)
    else $error("read done or refused not final");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind != tld_pkg::K_READ_DONE) |-> (out_data.count == '0))
    else $error("count set on non-done result");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.count <= 6'(tld_pkg::LINE_MAX)))
    else $error("count above line limit");

endmodule

bind tty_line_discipline tld_checker u_tld_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
